// File: sv/bev_ray_cast_range_defines.svh
// ---------------------------------------------------------------------------
// Ray cast range assertion macros
// Shared concurrent assertion forms for the ray cast blocks.
// ---------------------------------------------------------------------------
`ifndef BEV_RAY_CAST_RANGE_DEFINES_SVH
`define BEV_RAY_CAST_RANGE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BRC_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/brc_pkg.sv
// ---------------------------------------------------------------------------
// Ray cast range package
// Sizes, fixed-point constants, CORDIC table and control structs.
// ---------------------------------------------------------------------------
package brc_pkg;

    localparam int DEF_IMG_WIDTH      = 256;
    localparam int DEF_IMG_HEIGHT     = 256;
    localparam int DEF_MAX_RAYS       = 1024;
    localparam int DEF_MAX_STEP_LIMIT = 1023;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EGO_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EGO_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd7;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    localparam logic [7:0] PIXEL_THRESHOLD = 8'd128;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_IT_W  = 4;
    localparam int CORDIC_W     = 34;  // Q.30 plus headroom
    localparam int ZW           = 28;
    localparam int ANG_W        = 32;

    // angle modulo: one compare and subtract per cycle, 2*pi shifted down from 2^7
    localparam int MOD_STEPS = 8;
    localparam int MOD_CNT_W = 4;

    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q13  = 32'sd51472;
    localparam logic signed [ANG_W-1:0] PI_Q13      = 32'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 32'sd12868;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [CORDIC_IT_W-1:0] i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                4'd0:  v = 28'sd13176795;
                4'd1:  v = 28'sd7778716;
                4'd2:  v = 28'sd4110060;
                4'd3:  v = 28'sd2086331;
                4'd4:  v = 28'sd1047214;
                4'd5:  v = 28'sd524117;
                4'd6:  v = 28'sd262123;
                4'd7:  v = 28'sd131069;
                4'd8:  v = 28'sd65536;
                4'd9:  v = 28'sd32768;
                4'd10: v = 28'sd16384;
                4'd11: v = 28'sd8192;
                4'd12: v = 28'sd4096;
                4'd13: v = 28'sd2048;
                4'd14: v = 28'sd1024;
                default: v = 28'sd512;
            endcase
            return v;
        end
    endfunction

    // controller to datapath
    typedef struct packed {
        logic write_pixel;  // store input pixel bit
        logic load_ray;     // latch ray index, form angle
        logic mod_step;     // one compare and subtract of the angle modulo
        logic reduce;       // fold angle, seed CORDIC
        logic rotate;       // one CORDIC iteration
        logic finish_dir;   // round and form direction
        logic step_init;    // r = 1
        logic step_issue;   // compute position, read memory
        logic step_eval;    // look at memory bit
        logic set_miss_out; // load result register
    } brc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ray_valid;    // index in range
        logic mod_done;     // angle reduced below 2*pi
        logic cordic_last;
        logic limit_zero;
        logic pos_outside;  // last issued position left the image
        logic pix_set;      // memory bit at issued position
        logic last_step;    // r == limit
    } brc_status_t;

endpackage

// File: sv/brc_datapath.sv
// ---------------------------------------------------------------------------
// Ray cast datapath
// Bit image memory, angle reduction, shared CORDIC unit and ray walker.
// ---------------------------------------------------------------------------
module brc_datapath #(
    parameter int IMG_WIDTH      = brc_pkg::DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT     = brc_pkg::DEF_IMG_HEIGHT,
    parameter int MAX_RAYS       = brc_pkg::DEF_MAX_RAYS,
    parameter int MAX_STEP_LIMIT = brc_pkg::DEF_MAX_STEP_LIMIT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]                   pixel_col,
    input  logic [7:0]                   pixel_row,
    input  logic [7:0]                   pixel_value,
    input  logic [9:0]                   ray_index,
    input  brc_pkg::brc_cmd_t            cmd,
    output brc_pkg::brc_status_t         status,
    output logic [9:0]                   ray_number,
    output logic                         hit,
    output logic [9:0]                   range_steps
);
    import brc_pkg::*;

    localparam int XW   = $clog2(IMG_WIDTH);
    localparam int YW   = $clog2(IMG_HEIGHT);
    localparam int AW   = XW + YW;
    localparam int STW  = $clog2(MAX_STEP_LIMIT + 1);
    localparam int PW   = STW + 18;  // r * dir product

    // configuration
    logic [8:0]         image_width_reg, image_height_reg;
    logic [7:0]         ego_x_reg, ego_y_reg;
    logic [9:0]         max_steps_reg;
    logic [10:0]        ray_count_reg;
    logic signed [15:0] angle_start_reg;
    logic [12:0]        angle_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 9'd256;
            image_height_reg <= 9'd256;
            ego_x_reg        <= 8'd128;
            ego_y_reg        <= 8'd255;
            max_steps_reg    <= 10'd255;
            ray_count_reg    <= 11'd180;
            angle_start_reg  <= -16'sd12868;
            angle_step_reg   <= 13'd143;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[8:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[8:0];
                REG_EGO_X:        ego_x_reg        <= cfg_data[7:0];
                REG_EGO_Y:        ego_y_reg        <= cfg_data[7:0];
                REG_MAX_STEPS:    max_steps_reg    <= cfg_data[9:0];
                REG_RAY_COUNT:    ray_count_reg    <= cfg_data[10:0];
                REG_ANGLE_START:  angle_start_reg  <= cfg_data;
                default:          angle_step_reg   <= cfg_data[12:0];
            endcase
        end
    end

    // saturated limits
    logic [9:0] w_sat, h_sat;
    logic [STW-1:0] limit;
    assign w_sat = (32'(image_width_reg) > IMG_WIDTH) ? 10'(IMG_WIDTH) : 10'(image_width_reg);
    assign h_sat = (32'(image_height_reg) > IMG_HEIGHT) ? 10'(IMG_HEIGHT)
                                                        : 10'(image_height_reg);
    assign limit = (32'(max_steps_reg) > MAX_STEP_LIMIT) ? STW'(MAX_STEP_LIMIT)
                                                         : STW'(max_steps_reg);

    assign status.ray_valid  = (11'(ray_index) < ray_count_reg) &&
                               (32'(ray_index) < MAX_RAYS);
    assign status.limit_zero = (limit == '0);

    // image memory: write port and registered read
    logic img_mem [2**AW];
    logic rd_bit_reg;
    logic [AW-1:0] rd_addr;
    logic wr_ok;
    assign wr_ok = (32'(pixel_col) < IMG_WIDTH) && (32'(pixel_row) < IMG_HEIGHT);

    always_ff @(posedge clk)
    begin
        if (cmd.write_pixel && wr_ok)
            img_mem[{YW'(pixel_row), XW'(pixel_col)}] <= (pixel_value >= PIXEL_THRESHOLD);
        rd_bit_reg <= img_mem[rd_addr];
    end
    assign status.pix_set = rd_bit_reg;

    // angle formation; one 2*pi added up front keeps the angle positive
    logic [9:0]              idx_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [ANG_W-1:0] prod_full;
    logic signed [ANG_W-1:0] mod_sub_reg;
    logic [MOD_CNT_W-1:0]    mod_cnt_reg;
    assign prod_full = ANG_W'(angle_start_reg) + TWO_PI_Q13 +
                       $signed({1'b0, 23'(ray_index) * 23'(angle_step_reg)});
    assign status.mod_done = (mod_cnt_reg == '0);

    // fold the reduced angle into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] r1, r2, r3;
    logic                    neg_c;
    always_comb
    begin
        r1 = ang_reg;
        r2 = (r1 > PI_Q13) ? r1 - TWO_PI_Q13 : r1;
        neg_c = 1'b0;
        r3 = r2;
        if (r2 > HALF_PI_Q13)
        begin
            r3 = r2 - PI_Q13;
            neg_c = 1'b1;
        end
        else if (r2 < -HALF_PI_Q13)
        begin
            r3 = r2 + PI_Q13;
            neg_c = 1'b1;
        end
    end

    // CORDIC state
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [ZW-1:0]       z_reg;
    logic [CORDIC_IT_W-1:0]     it_reg;
    logic                       neg_reg;
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign status.cordic_last = (it_reg == CORDIC_IT_W'(CORDIC_STEPS - 1));

    function automatic logic signed [16:0] rnd15(input logic signed [CORDIC_W-1:0] v);
        logic [CORDIC_W-1:0] m;
        logic [CORDIC_W-1:0] q;
        begin
            m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
            q = (m + CORDIC_W'(16384)) >> 15;
            return v[CORDIC_W-1] ? -$signed(17'(q)) : $signed(17'(q));
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        begin
            if (v > 18'sd32767) return 16'sd32767;
            if (v < -18'sd32768) return -16'sd32768;
            return 16'(v);
        end
    endfunction

    logic signed [17:0] c_r, s_r;
    logic signed [15:0] c_s, s_s;
    always_comb
    begin
        c_r = 18'(rnd15(x_reg));
        s_r = 18'(rnd15(y_reg));
        if (neg_reg)
        begin
            c_r = -c_r;
            s_r = -s_r;
        end
        c_s = sat16(c_r);
        s_s = sat16(s_r);
    end

    logic signed [15:0] dir_x_reg, dir_y_reg;

    // walker
    logic [STW-1:0]       r_reg;
    logic signed [PW-1:0] px_prod, py_prod;
    logic signed [PW-1:0] offx, offy;
    logic signed [PW-1:0] posx, posy;
    logic                 outside_reg;

    assign px_prod = $signed({1'b0, r_reg}) * PW'(dir_x_reg);
    assign py_prod = $signed({1'b0, r_reg}) * PW'(dir_y_reg);

    function automatic logic signed [PW-1:0] rndp(input logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        logic [PW-1:0] q;
        begin
            m = v[PW-1] ? PW'(-v) : PW'(v);
            q = (m + PW'(16384)) >> 15;
            return v[PW-1] ? -$signed(q) : $signed(q);
        end
    endfunction

    always_comb
    begin
        offx = rndp(px_prod);
        offy = rndp(py_prod);
        posx = PW'(ego_x_reg) + offx;
        posy = PW'(ego_y_reg) + offy;
        rd_addr = {YW'(posy), XW'(posx)};
    end

    logic out_c;
    assign out_c = (posx < 0) || (posx >= PW'(w_sat)) || (posy < 0) || (posy >= PW'(h_sat));
    assign status.pos_outside = outside_reg;
    assign status.last_step   = (r_reg == limit);

    logic [9:0] ray_number_reg;
    logic [9:0] range_reg;
    logic       hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_ray)
        begin
            idx_reg     <= ray_index;
            ang_reg     <= prod_full;
            mod_sub_reg <= TWO_PI_Q13 <<< (MOD_STEPS - 1);
            mod_cnt_reg <= MOD_CNT_W'(MOD_STEPS);
        end
        else if (cmd.mod_step)
        begin
            if (ang_reg >= mod_sub_reg)
                ang_reg <= ang_reg - mod_sub_reg;
            mod_sub_reg <= mod_sub_reg >>> 1;
            mod_cnt_reg <= mod_cnt_reg - 1'b1;
        end
        if (cmd.reduce)
        begin
            x_reg   <= CORDIC_K;
            y_reg   <= '0;
            z_reg   <= ZW'(r3) <<< 11;
            it_reg  <= '0;
            neg_reg <= neg_c;
        end
        else if (cmd.rotate)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_lut(it_reg);
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_lut(it_reg);
            end
            it_reg <= it_reg + 1'b1;
        end
        if (cmd.finish_dir)
        begin
            dir_x_reg <= sat16(-18'(s_s));
            dir_y_reg <= sat16(-18'(c_s));
        end
        if (cmd.step_init)
            r_reg <= STW'(1);
        else if (cmd.step_eval)
            r_reg <= r_reg + 1'b1;
        if (cmd.step_issue)
            outside_reg <= out_c;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.set_miss_out)
        begin
            ray_number_reg <= idx_reg;
            // a set bit with the position inside is a hit at r
            hit_reg    <= cmd.step_eval && !outside_reg && rd_bit_reg;
            range_reg  <= (cmd.step_eval && !outside_reg && rd_bit_reg) ? 10'(r_reg)
                                                                          : 10'(limit);
        end
    end
    assign ray_number  = ray_number_reg;
    assign hit         = hit_reg;
    assign range_steps = range_reg;

endmodule

// File: sv/brc_control.sv
// ---------------------------------------------------------------------------
// Ray cast controller
// Sequences pixel writes, CORDIC iterations and the ray walk; owns handshakes.
// ---------------------------------------------------------------------------
`include "bev_ray_cast_range_defines.svh"

module brc_control (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  brc_pkg::brc_status_t status,
    output brc_pkg::brc_cmd_t    cmd
);
    import brc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_ROTATE = 7'b0000100,
        ST_DIR    = 7'b0001000,
        ST_ISSUE  = 7'b0010000,
        ST_EVAL   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_blocked;

    // a finished word waiting in the output register only blocks the next cast
    assign in_stall    = (state_reg != ST_IDLE) || (out_valid_reg && func == FUNC_CAST);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_WRITE)
                    cmd.write_pixel = 1'b1;
                else if (accept && status.ray_valid)
                begin
                    cmd.load_ray = 1'b1;
                    state_next   = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // subtract each shifted 2*pi that fits, down to 2*pi itself, then seed
                if (status.mod_done)
                begin
                    cmd.reduce = 1'b1;
                    state_next = ST_ROTATE;
                end
                else
                    cmd.mod_step = 1'b1;
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                if (status.cordic_last)
                    state_next = ST_DIR;
            end
            ST_DIR:
            begin
                cmd.finish_dir = 1'b1;
                cmd.step_init  = 1'b1;
                state_next     = status.limit_zero ? ST_OUT : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.step_issue = 1'b1;
                state_next     = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.step_eval = 1'b1;
                if (status.pos_outside || status.pix_set || status.last_step)
                begin
                    cmd.set_miss_out = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                    state_next = ST_ISSUE;
            end
            default:
            begin
                // zero step limit: plain miss
                cmd.set_miss_out = 1'b1;
                out_valid_next   = 1'b1;
                state_next       = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BRC_ASSERT_IMPL(a_one_hot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `BRC_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.set_miss_out, !out_blocked, "word lost")
    `BRC_ASSERT_NEXT(a_cast_starts, clk, rst_n, cmd.load_ray, state_reg == ST_REDUCE, "cast did not start")
    `BRC_ASSERT_IMPL(a_busy_stalls, clk, rst_n, state_reg != ST_IDLE, in_stall, "input taken while busy")

endmodule

// File: sv/bev_ray_cast_range.sv
// ---------------------------------------------------------------------------
// Bird's-eye ray cast range finder
// Bit image store plus CORDIC direction and pixel walk per ray.
// ---------------------------------------------------------------------------
// A pixel write is stored without the block leaving idle. A ray cast forms the
// angle, reduces it modulo 2*pi by compare and subtract, seeds the CORDIC, runs
// sixteen CORDIC iterations, forms the direction, then walks at most max_steps
// pixels (none when max_steps is 0), each step forming the address and then
// reading the registered image memory. The result word is offered on the cycle
// after the cast's final state; while it waits unread, further casts stall but
// pixel writes still go through. A cast whose index is not below ray_count
// gives no result and leaves the block idle. Load the whole image before
// casting rays.
module bev_ray_cast_range #(
    parameter int IMG_WIDTH      = brc_pkg::DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT     = brc_pkg::DEF_IMG_HEIGHT,
    parameter int MAX_RAYS       = brc_pkg::DEF_MAX_RAYS,
    parameter int MAX_STEP_LIMIT = brc_pkg::DEF_MAX_STEP_LIMIT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [7:0]                     pixel_col,
    input  logic [7:0]                     pixel_row,
    input  logic [7:0]                     pixel_value,
    input  logic [9:0]                     ray_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [9:0]                     ray_number,
    output logic                           hit,
    output logic [9:0]                     range_steps
);
    import brc_pkg::*;

    brc_cmd_t    cmd;
    brc_status_t status;

    brc_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    brc_datapath #(
        .IMG_WIDTH      (IMG_WIDTH),
        .IMG_HEIGHT     (IMG_HEIGHT),
        .MAX_RAYS       (MAX_RAYS),
        .MAX_STEP_LIMIT (MAX_STEP_LIMIT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .pixel_value (pixel_value),
        .ray_index   (ray_index),
        .cmd         (cmd),
        .status      (status),
        .ray_number  (ray_number),
        .hit         (hit),
        .range_steps (range_steps)
    );

endmodule

// File: dv/bev_ray_cast_range_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Ray cast range finder testbench
// Loads small bit images, casts rays under several register settings and
// checks every result word against an in-bench CORDIC and pixel-walk model.
// ---------------------------------------------------------------------------
module bev_ray_cast_range_tb;
    import brc_pkg::*;

    localparam int  CAST_LATENCY = 2100;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        int unsigned num;
        bit          hit;
        int unsigned rng;
    } ray_result_t;

    class ray_scoreboard;
        bit          img[65536];
        bit          known[65536];
        int unsigned width = 256, height = 256, ego_x = 128, ego_y = 255;
        int unsigned max_steps = 255, ray_count = 180, angle_step = 143;
        int          angle_start = -12868;
        longint      atan_q24[16] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                                      524117, 262123, 131069, 65536, 32768, 16384,
                                      8192, 4096, 2048, 1024, 512};
        ray_result_t expected_q[$];
        int          errors, casts, hits, writes;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_IMAGE_WIDTH:  width = v[8:0];
                REG_IMAGE_HEIGHT: height = v[8:0];
                REG_EGO_X:        ego_x = v[7:0];
                REG_EGO_Y:        ego_y = v[7:0];
                REG_MAX_STEPS:    max_steps = v[9:0];
                REG_RAY_COUNT:    ray_count = v[10:0];
                REG_ANGLE_START:  angle_start = $signed(v);
                default:          angle_step = v[12:0];
            endcase
        endfunction

        function longint sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint round_div(longint v, int s);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (64'sd1 <<< (s - 1))) >>> s;
            return (v < 0) ? -m : m;
        endfunction

        function void sin_cos(int a, output longint s, output longint c);
            int     r;
            bit     neg;
            longint x, y, z, xs, ys;
            r = a % 51472;
            neg = 0;
            x = 652032874;
            y = 0;
            if (r < 0) r += 51472;
            if (r > 25736) r -= 51472;
            if (r > 12868) begin r -= 25736; neg = 1; end
            else if (r < -12868) begin r += 25736; neg = 1; end
            z = longint'(r) * 2048;
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin x -= ys; y += xs; z -= atan_q24[i]; end
                else begin x += ys; y -= xs; z += atan_q24[i]; end
            end
            x = round_div(x, 15);
            y = round_div(y, 15);
            if (neg) begin x = -x; y = -y; end
            c = sat16(x);
            s = sat16(y);
        endfunction

        // walk one ray; flag a read of a pixel that was never loaded
        function bit trace(int unsigned idx, output bit h, output int unsigned rng);
            longint s, c, dx, dy, px, py;
            int unsigned w, ht, lim;
            bit          blind;
            blind = 0;
            h = 0;
            sin_cos(angle_start + int'(idx * angle_step), s, c);
            dx = sat16(-s);
            dy = sat16(-c);
            w = (width > 256) ? 256 : width;
            ht = (height > 256) ? 256 : height;
            lim = (max_steps > 1023) ? 1023 : max_steps;
            rng = lim;
            for (int r = 1; r <= lim; r++)
            begin
                px = ego_x + round_div(r * dx, 15);
                py = ego_y + round_div(r * dy, 15);
                if (px < 0 || px >= w || py < 0 || py >= ht) break;
                if (!known[py * 256 + px]) blind = 1;
                if (img[py * 256 + px])
                begin
                    h = 1;
                    rng = r;
                    break;
                end
            end
            return blind;
        endfunction

        function bit cast_allowed(int unsigned idx);
            bit          h;
            int unsigned rng;
            if (idx >= ray_count) return 1;
            return !trace(idx, h, rng);
        endfunction

        function void note_input(logic f, logic [7:0] col, logic [7:0] row,
                                 logic [7:0] val, logic [9:0] idx);
            ray_result_t e;
            if (f == FUNC_WRITE)
            begin
                img[row * 256 + col] = (val >= PIXEL_THRESHOLD);
                known[row * 256 + col] = 1;
                writes++;
                return;
            end
            if (idx >= ray_count) return;
            void'(trace(idx, e.hit, e.rng));
            e.num = idx;
            expected_q = {expected_q, e};
            casts++;
            if (e.hit) hits++;
        endfunction

        function void check_result(logic [9:0] num, logic h, logic [9:0] rng);
            ray_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: ray_number %0d", num);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (num !== e.num[9:0])
            begin
                $error("ray_number: expected %0d, got %0d", e.num, num);
                errors++;
            end
            if (h !== e.hit)
            begin
                $error("hit: expected %0d, got %0d", e.hit, h);
                errors++;
            end
            if (rng !== e.rng[9:0])
            begin
                $error("range_steps: expected %0d, got %0d", e.rng, rng);
                errors++;
            end
        endfunction
    endclass

    logic                  clk, rst_n, cfg_we, in_valid, in_stall, func;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [7:0]            pixel_col, pixel_row, pixel_value;
    logic [9:0]            ray_index, ray_number, range_steps;
    logic                  out_valid, out_stall, hit;

    ray_scoreboard sb;
    int            sent_words, result_words;
    longint        cycles;

    bev_ray_cast_range dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[bev_ray_cast_range] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[15:0];
        sb.set_reg(idx, v[15:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic f, logic [7:0] col, logic [7:0] row,
                             logic [7:0] val, logic [9:0] idx);
        // idle now and then, except for a calm stretch
        if (!(sent_words >= 200 && sent_words < 320) && $urandom_range(99) < 15)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func <= f;
        pixel_col <= col;
        pixel_row <= row;
        pixel_value <= val;
        ray_index <= idx;
        do @(posedge clk); while (in_stall);
        sb.note_input(f, col, row, val, idx);
        sent_words++;
    endtask

    task automatic put_pixel(int col, int row, int val);
        send_word(FUNC_WRITE, col[7:0], row[7:0], val[7:0], 10'd0);
    endtask

    // send a cast only if its walk stays on loaded pixels
    task automatic try_cast(int idx);
        if (sb.cast_allowed(idx))
            send_word(FUNC_CAST, 8'($urandom), 8'($urandom), 8'($urandom), idx[9:0]);
        else
            put_pixel($urandom_range(15), $urandom_range(15), $urandom);
    endtask

    // hold the input low until every expected word is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (CAST_LATENCY) @(posedge clk);
    endtask

    task automatic set_phase(int w, int h, int ex, int ey, int ms, int rc, int as, int st);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_EGO_X, ex);
        write_reg(REG_EGO_Y, ey);
        write_reg(REG_MAX_STEPS, ms);
        write_reg(REG_RAY_COUNT, rc);
        write_reg(REG_ANGLE_START, as);
        write_reg(REG_ANGLE_STEP, st);
    endtask

    task automatic random_words(int n);
        int cnt;
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2 && $urandom_range(1))
                drain();
            if ($urandom_range(99) < 70)
            begin
                cnt = (sb.ray_count > 1024) ? 1024 : sb.ray_count;
                if ($urandom_range(9) == 0) try_cast($urandom_range(1023));
                else try_cast($urandom_range(cnt - 1));
            end
            else if ($urandom_range(3) == 0)
                put_pixel($urandom_range(255), $urandom_range(255), $urandom);
            else
                put_pixel($urandom_range(15), $urandom_range(15), $urandom);
        end
    endtask

    // set square ring around (8,8) at distance 7: every ray stops on it
    task automatic load_ring();
        for (int i = 1; i <= 15; i++)
        begin
            put_pixel(i, 1, 255);
            put_pixel(i, 15, 200);
            put_pixel(1, i, 128);
            put_pixel(15, i, 255);
        end
    endtask

    // receiver side: random stall, a calm stretch and one long hold
    initial
    begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_result(ray_number, hit, range_steps);
                result_words++;
                if (result_words == 8) hold = 800;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (result_words >= 20 && result_words < 60)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 15);
        end
    end

    initial
    begin
        sb = new();
        sent_words = 0;
        result_words = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_WRITE;
        pixel_col = '0;
        pixel_row = '0;
        pixel_value = '0;
        ray_index = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // small image, widest range and angle extremes
        set_phase(16, 16, 5, 10, 1023, 1024, -25736, 4096);
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                put_pixel(c, r, ($urandom_range(99) < 25) ? $urandom_range(128, 255)
                                                           : $urandom_range(127));
        put_pixel(255, 255, 255);
        put_pixel(0, 0, 0);
        put_pixel(3, 4, 127);
        put_pixel(4, 3, 128);
        try_cast(0);
        try_cast(1023);
        try_cast(511);
        try_cast(12);
        random_words(30);

        set_phase(16, 16, 0, 0, 40, 100, 0, 1);
        try_cast(99);
        try_cast(100);
        random_words(20);

        // oversized image held in by a ring of set pixels
        set_phase(400, 300, 8, 8, 1023, 1024, 25736, 4095);
        load_ring();
        try_cast(0);
        try_cast(1023);
        random_words(30);

        // zero width: every ray leaves at once
        set_phase(0, 16, 8, 8, 10, 50, 12868, 2000);
        random_words(15);

        set_phase(1, 16, 0, 7, 5, 64, -12868, 3000);
        random_words(20);

        // no steps at all, ray count above the ray table
        set_phase(256, 511, 255, 255, 0, 2047, -1, 8191);
        try_cast(1023);
        random_words(20);

        set_phase(16, 16, 255, 3, 20, 1, 9000, 7);
        try_cast(0);
        try_cast(1);
        random_words(15);

        set_phase(256, 256, 8, 8, 300, 180, -12868, 143);
        load_ring();
        random_words(30);

        drain();
        repeat (CAST_LATENCY) @(posedge clk);

        $display("Covered %0d pixel writes and %0d ray results (%0d hits) over eight settings.",
                 sb.writes, sb.casts, sb.hits);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[bev_ray_cast_range] OK");
        else
            $display("[bev_ray_cast_range] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/brc_pkg.sv
sv/brc_datapath.sv
sv/brc_control.sv
sv/bev_ray_cast_range.sv
dv/bev_ray_cast_range_tb.sv
